@@ rtl/tts_pkg.sv @@
package tts_pkg;

  // Table geometry.
  localparam int SLOTS       = 16;
  localparam int MAX_RESULTS = 16;
  localparam int IW          = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW          = $clog2(SLOTS + 1);
  localparam int NW          = $clog2(MAX_RESULTS + 1);

  // Field widths.
  localparam int SLOT_W     = 4;
  localparam int TAG_W      = 8;
  localparam int TIME_W     = 32;
  localparam int PEND_W     = 8;
  localparam int REQ_W      = 2;
  localparam int STAT_W     = 3;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 16;
  localparam int CMP_W      = (CW > SLOT_W) ? CW : SLOT_W;

  localparam logic [CW-1:0]     CW_ONE   = CW'(1);
  localparam logic [CW-1:0]     SLOTS_C  = CW'(SLOTS);
  localparam logic [NW-1:0]     NW_ONE   = NW'(1);
  localparam logic [NW-1:0]     MAXR_C   = NW'(MAX_RESULTS);
  localparam logic [PEND_W-1:0] PEND_MAX = '1;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD, REQ_DEL, REQ_TICK, REQ_DISP
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_ADDED, ST_FULL, ST_DELETED, ST_DEL_IGN, ST_TICK_DONE, ST_FIRED, ST_NONE
  } status_t;

  typedef enum logic {S_IDLE, S_DISP} state_t;

  typedef enum logic [2:0] {C_NOP, C_LOAD, C_SHIFT, C_TICK, C_DEC} cell_op_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] delay;
    logic [TIME_W-1:0] period;
    logic [PEND_W-1:0] pending;
  } entry_t;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    cell_op_t      op;
    logic [IW-1:0] pos;
    entry_t        data;
  } cell_cmd_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic [TAG_W-1:0]  tag;
    logic              last;
  } result_t;

  function automatic logic slot_hit(input logic [SLOT_W-1:0] s, input logic [CW-1:0] cnt);
    slot_hit = CMP_W'(s) < CMP_W'(cnt);
  endfunction

  function automatic logic [IW-1:0] slot_pos(input logic [SLOT_W-1:0] s);
    slot_pos = IW'(s);
  endfunction

  function automatic logic [SLOT_W-1:0] slot_of(input logic [CW-1:0] p);
    slot_of = SLOT_W'(p);
  endfunction

endpackage

@@ rtl/tts_cell.sv @@
module tts_cell (
  input  logic                      clk,
  input  tts_pkg::cell_cmd_t        cmd,
  input  logic [tts_pkg::IW-1:0]    index,
  input  logic                      live,
  input  tts_pkg::entry_t           nbr,
  output tts_pkg::entry_t           ent
);

  // One table entry. Deletes move the upper neighbor's entry into this cell.
  always_ff @(posedge clk) begin
    case (cmd.op)
      tts_pkg::C_LOAD: begin
        if (index == cmd.pos) begin
          ent <= cmd.data;
        end
      end
      tts_pkg::C_SHIFT: begin
        if (index >= cmd.pos) begin
          ent <= nbr;
        end
      end
      tts_pkg::C_TICK: begin
        if (live) begin
          if (ent.delay == '0) begin
            if (ent.pending != tts_pkg::PEND_MAX) begin
              ent.pending <= ent.pending + 8'd1;
            end
            if (ent.period != '0) begin
              ent.delay <= ent.period;
            end
          end else begin
            ent.delay <= ent.delay - 32'd1;
          end
        end
      end
      tts_pkg::C_DEC: begin
        if (index == cmd.pos) begin
          ent.pending <= ent.pending - 8'd1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/tick_task_scheduler_table.sv @@
// Add, delete and tick requests each yield one result beat, which passes through the
// staging and output registers; a new request is taken every cycle while staging is free.
// A dispatch walks the table one slot per cycle unless a held fire waits for staging,
// holding off new requests until the walk ends, and emits at most one fired beat per cycle.
// Reset clears the task count and all handshake state; the slot contents are
// undefined until written and need no clearing pass.
module tick_task_scheduler_table (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // Fields from bit 0: task_tag[7:0], first_delay[39:8], period[71:40], slot[75:72].
  input  logic [tts_pkg::IN_DATA_W-1:0]     s_tdata,
  // Fields from bit 0: req_type[1:0].
  input  logic [tts_pkg::REQ_W-1:0]         s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // Fields from bit 0: slot_out[3:0], fired_tag[11:4].
  output logic [tts_pkg::OUT_DATA_W-1:0]    m_tdata,
  // Fields from bit 0: status[2:0].
  output logic [tts_pkg::STAT_W-1:0]        m_tuser,
  output logic                              m_tlast
);

  // Input beat fields.
  tts_pkg::req_t                   req;
  logic [tts_pkg::TAG_W-1:0]       in_tag;
  logic [tts_pkg::TIME_W-1:0]      in_delay;
  logic [tts_pkg::TIME_W-1:0]      in_period;
  logic [tts_pkg::SLOT_W-1:0]      in_slot;

  assign req       = tts_pkg::req_t'(s_tuser);
  assign in_tag    = s_tdata[7:0];
  assign in_delay  = s_tdata[39:8];
  assign in_period = s_tdata[71:40];
  assign in_slot   = s_tdata[75:72];

  // Control registers.
  tts_pkg::state_t                 state, state_next;
  logic [tts_pkg::CW-1:0]          count, count_next;
  logic [tts_pkg::CW-1:0]          ptr, ptr_next;
  logic [tts_pkg::NW-1:0]          nres, nres_next;

  // A fired result is held back one step, because only the next fire (or the end
  // of the walk) tells whether it is the last beat of the dispatch.
  logic                            hv, hv_next;
  logic [tts_pkg::SLOT_W-1:0]      hslot, hslot_next;
  logic [tts_pkg::TAG_W-1:0]       htag, htag_next;

  // Staging register and output register form a two-beat result queue, so a
  // result waiting downstream does not stop the next request from being taken.
  logic                            stv, ov;
  tts_pkg::result_t                st, ob, st_data;
  logic                            st_write, out_free, st_free;

  // Cell row.
  tts_pkg::cell_cmd_t              cmd;
  tts_pkg::entry_t                 ent [tts_pkg::SLOTS];
  logic [tts_pkg::SLOTS-1:0]       live;
  tts_pkg::entry_t                 sel;
  logic                            done;

  for (genvar j = 0; j < tts_pkg::SLOTS; j++) begin : g_cell
    localparam int unsigned JI = j;
    tts_pkg::entry_t nbr;

    if (j == tts_pkg::SLOTS - 1) begin : g_top
      assign nbr = ent[j];
    end else begin : g_mid
      assign nbr = ent[j+1];
    end

    assign live[j] = count > JI[tts_pkg::CW-1:0];

    tts_cell u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .index (JI[tts_pkg::IW-1:0]),
      .live  (live[j]),
      .nbr   (nbr),
      .ent   (ent[j])
    );
  end

  // The dispatch walk looks at one slot per cycle, unless a held fire waits for staging.
  assign sel      = ent[ptr[tts_pkg::IW-1:0]];
  assign done     = (ptr >= count) || (nres == tts_pkg::MAXR_C);
  assign out_free = !ov || m_tready;
  assign st_free  = !stv || out_free;

  always_comb begin
    state_next = state;
    count_next = count;
    ptr_next   = ptr;
    nres_next  = nres;
    hv_next    = hv;
    hslot_next = hslot;
    htag_next  = htag;
    st_write   = 1'b0;
    st_data    = '{status: tts_pkg::ST_NONE, slot: '0, tag: '0, last: 1'b1};
    cmd        = '{op: tts_pkg::C_NOP, pos: '0, data: '0};
    s_tready   = 1'b0;

    unique case (state)
      tts_pkg::S_IDLE: begin
        s_tready = st_free;
        if (s_tvalid && st_free) begin
          unique case (req)
            tts_pkg::REQ_ADD: begin
              st_write = 1'b1;
              if (count < tts_pkg::SLOTS_C) begin
                cmd = '{op: tts_pkg::C_LOAD, pos: count[tts_pkg::IW-1:0],
                        data: '{tag: in_tag, delay: in_delay, period: in_period,
                                pending: '0}};
                count_next = count + tts_pkg::CW_ONE;
                st_data = '{status: tts_pkg::ST_ADDED, slot: tts_pkg::slot_of(count),
                            tag: in_tag, last: 1'b1};
              end else begin
                st_data = '{status: tts_pkg::ST_FULL, slot: '0, tag: '0, last: 1'b1};
              end
            end
            tts_pkg::REQ_DEL: begin
              st_write = 1'b1;
              if (tts_pkg::slot_hit(in_slot, count)) begin
                cmd.op     = tts_pkg::C_SHIFT;
                cmd.pos    = tts_pkg::slot_pos(in_slot);
                count_next = count - tts_pkg::CW_ONE;
                st_data = '{status: tts_pkg::ST_DELETED, slot: in_slot, tag: '0,
                            last: 1'b1};
              end else begin
                st_data = '{status: tts_pkg::ST_DEL_IGN, slot: in_slot, tag: '0,
                            last: 1'b1};
              end
            end
            tts_pkg::REQ_TICK: begin
              st_write = 1'b1;
              cmd.op   = tts_pkg::C_TICK;
              st_data  = '{status: tts_pkg::ST_TICK_DONE, slot: '0, tag: '0, last: 1'b1};
            end
            tts_pkg::REQ_DISP: begin
              state_next = tts_pkg::S_DISP;
              ptr_next   = '0;
              nres_next  = '0;
              hv_next    = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end

      tts_pkg::S_DISP: begin
        if (done) begin
          // Close the walk with the held fire marked last, or report nothing ready.
          if (st_free) begin
            st_write = 1'b1;
            if (hv) begin
              st_data = '{status: tts_pkg::ST_FIRED, slot: hslot, tag: htag, last: 1'b1};
            end
            hv_next    = 1'b0;
            state_next = tts_pkg::S_IDLE;
          end
        end else if (sel.pending != '0) begin
          if (!hv || st_free) begin
            if (hv) begin
              st_write = 1'b1;
              st_data  = '{status: tts_pkg::ST_FIRED, slot: hslot, tag: htag, last: 1'b0};
            end
            hv_next    = 1'b1;
            hslot_next = tts_pkg::slot_of(ptr);
            htag_next  = sel.tag;
            nres_next  = nres + tts_pkg::NW_ONE;
            cmd.pos    = ptr[tts_pkg::IW-1:0];
            if (sel.period == '0) begin
              // A one-shot task leaves the table; the walk stays on this position,
              // which now holds the next entry.
              cmd.op     = tts_pkg::C_SHIFT;
              count_next = count - tts_pkg::CW_ONE;
            end else begin
              cmd.op   = tts_pkg::C_DEC;
              ptr_next = ptr + tts_pkg::CW_ONE;
            end
          end
        end else begin
          ptr_next = ptr + tts_pkg::CW_ONE;
        end
      end

      default: begin
        state_next = tts_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tts_pkg::S_IDLE;
      count <= '0;
      ptr   <= '0;
      nres  <= '0;
      hv    <= 1'b0;
      stv   <= 1'b0;
      ov    <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      ptr   <= ptr_next;
      nres  <= nres_next;
      hv    <= hv_next;
      if (st_write) begin
        stv <= 1'b1;
      end else if (out_free) begin
        stv <= 1'b0;
      end
      if (stv && out_free) begin
        ov <= 1'b1;
      end else if (m_tready) begin
        ov <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    hslot <= hslot_next;
    htag  <= htag_next;
    if (st_write) begin
      st <= st_data;
    end
    if (stv && out_free) begin
      ob <= st;
    end
  end

  assign m_tvalid = ov;
  assign m_tdata  = {{(tts_pkg::OUT_DATA_W - tts_pkg::SLOT_W - tts_pkg::TAG_W){1'b0}},
                     ob.tag, ob.slot};
  assign m_tuser  = ob.status;
  assign m_tlast  = ob.last;

  // The table never holds more entries than it has cells.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= tts_pkg::SLOTS_C)
    else $error("task count exceeds table size");

  // A held fire exists only while a dispatch walk is running.
  a_hold_in_walk: assert property (@(posedge clk) disable iff (rst)
    hv |-> state == tts_pkg::S_DISP)
    else $error("held fire outside dispatch");

  // A single-beat request always leaves its result in the staging register.
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && req != tts_pkg::REQ_DISP) |=> stv)
    else $error("request result not staged");

  // A delete of a live slot shrinks the table by exactly one.
  a_delete_count: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && req == tts_pkg::REQ_DEL && tts_pkg::slot_hit(in_slot, count))
      |=> count == $past(count) - tts_pkg::CW_ONE)
    else $error("delete did not shrink the table");

  // The walk never emits more fired beats than the cap.
  a_result_cap: assert property (@(posedge clk) disable iff (rst)
    state == tts_pkg::S_DISP |-> nres <= tts_pkg::MAXR_C)
    else $error("dispatch exceeded result cap");

endmodule

@@ sim/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tts_pkg::*;

  // Scoreboard: keeps its own copy of the task table, works out the beats that every
  // accepted request must produce, and checks the beats coming out of the block in order.
  class sched_scoreboard;
    logic [TAG_W-1:0]  tags    [SLOTS];
    logic [TIME_W-1:0] delays  [SLOTS];
    logic [TIME_W-1:0] periods [SLOTS];
    logic [PEND_W-1:0] runs    [SLOTS];
    int unsigned       live;
    result_t           due_beats[$];
    int unsigned       errors;
    int unsigned       requests;
    int unsigned       beats_by_status[8];

    function new();
      live = 0;
      errors = 0;
      requests = 0;
      foreach (beats_by_status[k]) beats_by_status[k] = 0;
    endfunction

    function result_t mk_beat(status_t st, int unsigned sl, logic [TAG_W-1:0] tg, logic lst);
      result_t b;
      b.status = st;
      b.slot = SLOT_W'(sl);
      b.tag = tg;
      b.last = lst;
      return b;
    endfunction

    // Removing an entry closes the gap, so slot numbers always equal positions.
    function void drop_entry(int unsigned pos);
      for (int unsigned k = pos; k + 1 < live; k++) begin
        tags[k] = tags[k + 1];
        delays[k] = delays[k + 1];
        periods[k] = periods[k + 1];
        runs[k] = runs[k + 1];
      end
      live--;
    endfunction

    task report(string what, int unsigned want, int unsigned got);
      errors++;
      if (errors <= 40)
        $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    endtask

    function void note_request(req_t req, logic [TAG_W-1:0] tg, logic [TIME_W-1:0] dly,
                               logic [TIME_W-1:0] per, logic [SLOT_W-1:0] sl);
      int unsigned i;
      int unsigned fired;
      result_t b;
      requests++;
      case (req)
        REQ_ADD: begin
          if (live < SLOTS) begin
            tags[live] = tg;
            delays[live] = dly;
            periods[live] = per;
            runs[live] = '0;
            due_beats.push_back(mk_beat(ST_ADDED, live, tg, 1'b1));
            live++;
          end else begin
            due_beats.push_back(mk_beat(ST_FULL, 0, '0, 1'b1));
          end
        end
        REQ_DEL: begin
          if (sl < live) begin
            drop_entry(sl);
            due_beats.push_back(mk_beat(ST_DELETED, sl, '0, 1'b1));
          end else begin
            due_beats.push_back(mk_beat(ST_DEL_IGN, sl, '0, 1'b1));
          end
        end
        REQ_TICK: begin
          for (i = 0; i < live; i++) begin
            if (delays[i] == '0) begin
              if (runs[i] != PEND_MAX) runs[i]++;
              if (periods[i] != '0) delays[i] = periods[i];
            end else begin
              delays[i]--;
            end
          end
          due_beats.push_back(mk_beat(ST_TICK_DONE, 0, '0, 1'b1));
        end
        default: begin
          // A one-shot entry leaves the table after it fires; the walk then looks at
          // the same position again, which now holds the next entry.
          i = 0;
          fired = 0;
          while (i < live && fired < MAX_RESULTS) begin
            if (runs[i] != '0) begin
              runs[i]--;
              due_beats.push_back(mk_beat(ST_FIRED, i, tags[i], 1'b0));
              fired++;
              if (periods[i] == '0) begin
                drop_entry(i);
                continue;
              end
            end
            i++;
          end
          if (fired == 0) begin
            due_beats.push_back(mk_beat(ST_NONE, 0, '0, 1'b1));
          end else begin
            b = due_beats.pop_back();
            b.last = 1'b1;
            due_beats.push_back(b);
          end
        end
      endcase
    endfunction

    task check_beat(logic [STAT_W-1:0] st, logic [SLOT_W-1:0] sl, logic [TAG_W-1:0] tg,
                    logic lst);
      result_t want;
      if (due_beats.size() == 0) begin
        report("unexpected result beat, status", 0, st);
      end else begin
        want = due_beats.pop_front();
        beats_by_status[want.status]++;
        if (st !== want.status) report("status", want.status, st);
        if (sl !== want.slot) report("slot_out", want.slot, sl);
        if (tg !== want.tag) report("fired_tag", want.tag, tg);
        if (lst !== want.last) report("tlast", want.last, lst);
      end
    endtask
  endclass

  // Stop the run when this many cycles in a row pass without a beat on either side.
  localparam int unsigned QUIET_LIMIT = 4000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [REQ_W-1:0]      s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [STAT_W-1:0]     m_tuser;
  logic                  m_tlast;

  sched_scoreboard sb;

  tick_task_scheduler_table i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver switches between modes at random intervals: always ready, randomly
  // ready with a chance of three in four, or ready with occasional random stalls.
  int unsigned ready_mode = 0;
  int unsigned mode_left = 0;
  int unsigned stall_left = 0;

  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode <= $urandom_range(0, 2);
      mode_left <= $urandom_range(40, 200);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (ready_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (stall_left != 0) begin
          m_tready <= 1'b0;
          stall_left <= stall_left - 1;
        end else begin
          m_tready <= 1'b1;
          if ($urandom_range(0, 3) == 0) stall_left <= $urandom_range(1, 8);
        end
      end
    endcase
  end

  // Result beats are checked at the edge that accepts them. Reading the outputs in the
  // active region gives the values that the handshake saw at that edge.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_beat(m_tuser, m_tdata[SLOT_W-1:0], m_tdata[SLOT_W +: TAG_W], m_tlast);
  end

  // Watchdog: a hung handshake on either side shows up as a long quiet stretch.
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no beat for %0d cycles, %0d results outstanding",
               quiet_cycles, sb.due_beats.size());
      $display("tick_task_scheduler_table test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // The sender works in bursts. At the end of a burst it drops tvalid for a random gap,
  // mostly short but now and then long enough to leave the block idle, then starts a
  // new burst. Some bursts are long, giving stretches with no idling at all.
  int unsigned burst_left = 0;

  task automatic pace();
    int unsigned gap;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 25) : $urandom_range(0, 3);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
    end
  endtask

  // Presents one request, waits for the edge that accepts it, and lets the scoreboard
  // work out the beats it causes.
  task automatic send_req(req_t req, logic [TAG_W-1:0] tg, logic [TIME_W-1:0] dly,
                          logic [TIME_W-1:0] per, logic [SLOT_W-1:0] sl);
    s_tvalid <= 1'b1;
    s_tuser <= req;
    s_tdata <= {4'b0000, sl, per, dly, tg};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(req, tg, dly, per, sl);
    pace();
  endtask

  // Holds off the sender until every expected beat has come out.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.due_beats.size() != 0) @(posedge clk);
  endtask

  // Times are mostly tiny so that tasks actually come due, with a full-range value now
  // and then so that every bit of the delay and period fields moves.
  function automatic logic [TIME_W-1:0] pick_time();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return $urandom_range(0, 3);
  endfunction

  // One random request. Fields that the request does not use still carry random values.
  task automatic send_random();
    int unsigned pick;
    logic [SLOT_W-1:0] sl;
    req_t req;
    pick = $urandom_range(0, 99);
    if (pick < 30) req = REQ_ADD;
    else if (pick < 45) req = REQ_DEL;
    else if (pick < 75) req = REQ_TICK;
    else req = REQ_DISP;
    // Deletes mostly hit a live entry; the rest fall anywhere in the slot range.
    if (req == REQ_DEL && sb.live != 0 && $urandom_range(0, 4) != 0)
      sl = SLOT_W'($urandom_range(0, sb.live - 1));
    else
      sl = SLOT_W'($urandom_range(0, 15));
    if (req == REQ_ADD)
      send_req(req, TAG_W'($urandom_range(0, 255)), pick_time(), pick_time(), sl);
    else
      send_req(req, TAG_W'($urandom_range(0, 255)), $urandom, $urandom, sl);
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. An empty table: nothing to dispatch, nothing to delete.
    send_req(REQ_DISP, '0, '0, '0, '0);
    send_req(REQ_DEL, '0, '0, '0, 4'hF);
    // Fill the table. Slot 0 is a one-shot that is due at once, slot 1 carries every
    // extreme value and never comes due, slot 2 is a one-shot that is one tick away.
    send_req(REQ_ADD, 8'hFF, '0, '0, '0);
    send_req(REQ_ADD, 8'h00, '1, '1, '0);
    send_req(REQ_ADD, 8'hA5, 32'd1, '0, '0);
    for (int k = 3; k < SLOTS; k++)
      send_req(REQ_ADD, TAG_W'($urandom_range(1, 254)), '0, 32'd1, '0);
    // One add too many.
    send_req(REQ_ADD, 8'h5A, '0, '0, '0);
    // After one tick the first one-shot fires and leaves; the walk must not skip the
    // entry that slides into its place, and the one-shot that is not yet due stays.
    send_req(REQ_TICK, '0, '0, '0, '0);
    send_req(REQ_DISP, '0, '0, '0, '0);
    // Now the second one-shot sits in slot 1, behind the entry that never comes due, and fires on the next tick.
    send_req(REQ_TICK, '0, '0, '0, '0);
    send_req(REQ_DISP, '0, '0, '0, '0);
    // A delete at the front, and one just past the end of the table.
    send_req(REQ_DEL, '0, '0, '0, '0);
    send_req(REQ_DEL, '0, '0, '0, SLOT_W'(sb.live));
    drain();

    // A full table of one-shots that are due at once: one tick makes all sixteen
    // pending, and the dispatch that follows fires all of them, the most one request
    // can produce. That empties the table, so the next dispatch finds nothing.
    while (sb.live != 0)
      send_req(REQ_DEL, '0, '0, '0, SLOT_W'($urandom_range(0, sb.live - 1)));
    for (int k = 0; k < SLOTS; k++)
      send_req(REQ_ADD, TAG_W'($urandom_range(0, 255)), '0, '0, '0);
    send_req(REQ_TICK, '0, '0, '0, '0);
    send_req(REQ_DISP, '0, '0, '0, '0);
    send_req(REQ_DISP, '0, '0, '0, '0);
    drain();

    // Random part, with an occasional pause until the block has gone quiet.
    for (int n = 0; n < 200; n++) begin
      send_random();
      if (n == 100 || $urandom_range(0, 59) == 0) drain();
    end

    // Wind down: every expected beat must arrive, and no stray beat may follow.
    drain();
    repeat (2 * SLOTS + 8) @(posedge clk);

    $display("run covered %0d requests and %0d result beats", sb.requests,
             sb.beats_by_status[ST_ADDED] + sb.beats_by_status[ST_FULL] +
             sb.beats_by_status[ST_DELETED] + sb.beats_by_status[ST_DEL_IGN] +
             sb.beats_by_status[ST_TICK_DONE] + sb.beats_by_status[ST_FIRED] +
             sb.beats_by_status[ST_NONE]);
    $display("added %0d, full %0d, deleted %0d, delete ignored %0d, ",
             sb.beats_by_status[ST_ADDED], sb.beats_by_status[ST_FULL],
             sb.beats_by_status[ST_DELETED], sb.beats_by_status[ST_DEL_IGN],
             "ticks %0d, fired %0d, idle %0d",
             sb.beats_by_status[ST_TICK_DONE], sb.beats_by_status[ST_FIRED],
             sb.beats_by_status[ST_NONE]);
    if (sb.errors == 0) begin
      $display("tick_task_scheduler_table test passed");
    end else begin
      $display("tick_task_scheduler_table test failed");
    end
    $finish;
  end

endmodule
